// ----- src/annotation_word_encoder_macros.svh -----
// Assertion helpers shared by the encoder RTL.
`ifndef ANNOTATION_WORD_ENCODER_MACROS_SVH
`define ANNOTATION_WORD_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define AWE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("awe check failed");

// Next-cycle implication, disabled while reset is high.
`define AWE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("awe check failed");

`endif

// ----- src/awe_pkg.sv -----
package awe_pkg;

  localparam int NSLOT = 8;

  // request codes
  localparam logic [1:0] REQ_ANN    = 2'd0;
  localparam logic [1:0] REQ_AUX    = 2'd1;
  localparam logic [1:0] REQ_EOF    = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // pseudo-word codes, upper 6 bits of a word
  localparam logic [5:0] CODE_SKIP = 6'd59;
  localparam logic [5:0] CODE_NUM  = 6'd60;
  localparam logic [5:0] CODE_SUB  = 6'd61;
  localparam logic [5:0] CODE_CHN  = 6'd62;
  localparam logic [5:0] CODE_AUX  = 6'd63;

  // word slots, emitted lowest first
  localparam logic [2:0] SLOT_SKIP = 3'd0;
  localparam logic [2:0] SLOT_HI   = 3'd1;
  localparam logic [2:0] SLOT_LO   = 3'd2;
  localparam logic [2:0] SLOT_MAIN = 3'd3;
  localparam logic [2:0] SLOT_SUB  = 3'd4;
  localparam logic [2:0] SLOT_CHN  = 3'd5;
  localparam logic [2:0] SLOT_NUM  = 3'd6;
  localparam logic [2:0] SLOT_AUX  = 3'd7;

  typedef struct packed {
    logic [30:0] prev_time;
    logic [7:0]  prev_channel;
    logic [7:0]  prev_number;
    logic        order_flag;
  } state_t;

  typedef struct packed {
    logic [NSLOT-1:0]       mask;
    logic [NSLOT-1:0][15:0] slot_word;
    logic                   flag;
  } frame_t;

endpackage

// ----- src/awe_if.sv -----
interface awe_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [30:0]        ann_time;
  logic [5:0]         ann_type;
  logic signed [7:0]  ann_subtype;
  logic [7:0]         ann_channel;
  logic signed [7:0]  ann_number;
  logic [7:0]         aux_length;
  logic [7:0]         aux_first;
  logic [7:0]         aux_second;

  modport source (
    output valid, req_type, ann_time, ann_type, ann_subtype, ann_channel,
           ann_number, aux_length, aux_first, aux_second,
    input  ready
  );
  modport sink (
    input  valid, req_type, ann_time, ann_type, ann_subtype, ann_channel,
           ann_number, aux_length, aux_first, aux_second,
    output ready
  );
endinterface

interface awe_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] word;
  logic        last_word;
  logic        order_violation;

  modport source (output valid, word, last_word, order_violation, input ready);
  modport sink   (input valid, word, last_word, order_violation, output ready);
endinterface

// ----- src/awe_frame_build.sv -----
module awe_frame_build (
  input  logic [1:0]        req_type,
  input  logic [30:0]       ann_time,
  input  logic [5:0]        ann_type,
  input  logic signed [7:0] ann_subtype,
  input  logic [7:0]        ann_channel,
  input  logic signed [7:0] ann_number,
  input  logic [7:0]        aux_length,
  input  logic [7:0]        aux_first,
  input  logic [7:0]        aux_second,
  input  awe_pkg::state_t   st,
  output awe_pkg::state_t   st_next,
  output awe_pkg::frame_t   frame
);
  import awe_pkg::*;

  logic [31:0] delta;
  logic [31:0] delta_m1;
  logic [31:0] skip_val;
  logic        neg;
  logic        long_step;
  logic        null_type;
  logic        order_miss;
  logic [9:0]  step;

  // t - prev - 1 == t + ~prev, so both run in parallel
  assign delta     = {1'b0, ann_time} - {1'b0, st.prev_time};
  assign delta_m1  = {1'b0, ann_time} + ~{1'b0, st.prev_time};
  assign neg       = delta[31];
  assign long_step = neg | (|delta[30:10]);
  assign null_type = (ann_type == 6'd0);
  assign skip_val  = null_type ? delta_m1 : delta;
  assign step      = null_type ? 10'd1 : (long_step ? 10'd0 : delta[9:0]);

  // both times zero is the start of a file, never out of order
  assign order_miss = (neg || (delta == 32'd0 && ann_channel <= st.prev_channel)) &&
                      (ann_time != 31'd0 || st.prev_time != 31'd0);

  always_comb begin
    frame.mask      = '0;
    frame.slot_word = '0;
    frame.flag      = st.order_flag;
    st_next         = st;
    unique case (req_type)
      REQ_ANN: begin
        frame.flag                 = st.order_flag | order_miss;
        frame.mask[SLOT_SKIP]      = null_type | long_step;
        frame.mask[SLOT_HI]        = null_type | long_step;
        frame.mask[SLOT_LO]        = null_type | long_step;
        frame.mask[SLOT_MAIN]      = 1'b1;
        frame.mask[SLOT_SUB]       = (ann_subtype != 8'sd0);
        frame.mask[SLOT_CHN]       = (ann_channel != st.prev_channel);
        frame.mask[SLOT_NUM]       = ($unsigned(ann_number) != st.prev_number);
        frame.mask[SLOT_AUX]       = (aux_length != 8'd0);
        frame.slot_word[SLOT_SKIP] = {CODE_SKIP, 10'd0};
        frame.slot_word[SLOT_HI]   = skip_val[31:16];
        frame.slot_word[SLOT_LO]   = skip_val[15:0];
        frame.slot_word[SLOT_MAIN] = {ann_type, step};
        frame.slot_word[SLOT_SUB]  = {CODE_SUB, {2{ann_subtype[7]}}, ann_subtype};
        frame.slot_word[SLOT_CHN]  = {CODE_CHN, 2'b00, ann_channel};
        frame.slot_word[SLOT_NUM]  = {CODE_NUM, {2{ann_number[7]}}, ann_number};
        frame.slot_word[SLOT_AUX]  = {CODE_AUX, 2'b00, aux_length};
        st_next.prev_time          = ann_time;
        st_next.prev_channel       = ann_channel;
        st_next.prev_number        = $unsigned(ann_number);
        st_next.order_flag         = st.order_flag | order_miss;
      end
      REQ_AUX: begin
        frame.mask[SLOT_MAIN]      = 1'b1;
        frame.slot_word[SLOT_MAIN] = {aux_second, aux_first};
      end
      REQ_EOF: begin
        // zero end word carries the flag as it was, then everything clears
        frame.mask[SLOT_MAIN] = 1'b1;
        st_next               = '0;
      end
      REQ_UNUSED: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/annotation_word_encoder.sv -----
// Annotation word encoder, MIT annotation format.
// items (sink): one request per handshake; an annotation record, an aux byte
//   pair or an end-of-file marker, selected by req_type. Code 3 is taken and
//   dropped without output.
// words (source): 16-bit file words, one per handshake. last_word marks the
//   final word of a request; order_violation is the sticky order flag.
// The first word of a request is valid in the cycle after it is taken.
// Throughput: one word per cycle while words.ready is high. A request gives
//   one word per pending slot, 1 to 8; a record with a long or null time
//   step and every optional pseudo-word gives 8. The word frame register is
//   the only buffer: the next request is taken in the same cycle the last word
//   of this one is taken, so single-word requests stream at one per cycle.
// Receiver stall: the current word holds and items.ready stays low until the
//   frame's last word is taken.
// Reset (rst, synchronous): previous time, channel, number and the order flag
//   clear to zero and any pending words are dropped. An end-of-file request
//   clears the same state when it is taken; its zero word keeps the old flag.
`include "annotation_word_encoder_macros.svh"

module annotation_word_encoder (
  input logic        clk,
  input logic        rst,
  awe_item_if.sink   items,
  awe_word_if.source words
);
  import awe_pkg::*;

  state_t                 st;
  state_t                 st_next;
  frame_t                 frame;
  logic [NSLOT-1:0]       mask;
  logic [NSLOT-1:0]       mask_next;
  logic [NSLOT-1:0][15:0] slot_word;
  logic                   flag;
  logic [NSLOT-1:0]       mask_rest;
  logic [2:0]             sel;
  logic                   in_take;
  logic                   out_take;

  awe_frame_build u_build (
    .req_type    (items.req_type),
    .ann_time    (items.ann_time),
    .ann_type    (items.ann_type),
    .ann_subtype (items.ann_subtype),
    .ann_channel (items.ann_channel),
    .ann_number  (items.ann_number),
    .aux_length  (items.aux_length),
    .aux_first   (items.aux_first),
    .aux_second  (items.aux_second),
    .st          (st),
    .st_next     (st_next),
    .frame       (frame)
  );

  // lowest pending slot goes out first
  always_comb begin
    sel = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (mask[i]) sel = 3'(i);
    end
  end

  assign mask_rest = mask & (mask - {{(NSLOT-1){1'b0}}, 1'b1});

  assign words.valid           = |mask;
  assign words.word            = slot_word[sel];
  assign words.last_word       = (mask_rest == '0);
  assign words.order_violation = flag;

  assign items.ready = !(|mask) || (words.ready && words.last_word);
  assign in_take     = items.valid && items.ready;
  assign out_take    = words.valid && words.ready;

  always_comb begin
    mask_next = mask;
    if (out_take) mask_next = mask_rest;
    if (in_take)  mask_next = frame.mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= '0;
      mask <= '0;
    end else begin
      mask <= mask_next;
      if (in_take) st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      slot_word <= frame.slot_word;
      flag      <= frame.flag;
    end
  end

  `AWE_ASSERT_NXT(a_more_words, clk, rst, out_take && !words.last_word, words.valid)
  `AWE_ASSERT_IMP(a_ready_busy, clk, rst, (|mask) && items.ready,
                  words.ready && words.last_word)
  `AWE_ASSERT_NXT(a_eof_clear, clk, rst, in_take && items.req_type == REQ_EOF,
                  st == '0)
  `AWE_ASSERT_NXT(a_flag_sticky, clk, rst,
                  st.order_flag && !(in_take && items.req_type == REQ_EOF), st.order_flag)

endmodule
